FILE: hdl/sttq_pkg.sv
package sttq_pkg;

    localparam int PTR_W = 6;
    localparam logic [PTR_W-1:0] NO_SLOT = 6'd63;
    localparam logic [31:0] SWITCH_MARK = 32'h00FF_FFFF;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_ALLOC   = 3'd1;
    localparam logic [2:0] MODE_RESET   = 3'd2;
    localparam logic [2:0] MODE_CANCEL  = 3'd3;
    localparam logic [2:0] MODE_RELEASE = 3'd4;
    localparam logic [2:0] MODE_PURGE   = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE, OP_TICK, OP_ALLOC, OP_RESET, OP_CANCEL, OP_RELEASE, OP_PURGE
    } t_op;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_IDLE = 2'd1,
        ST_RUN  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_EXPIRY = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ALLOC  = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        AFT_ARM, AFT_IDLE, AFT_FREE
    } t_after;

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_UNLINK, S_ARM, S_INSERT, S_LINK, S_HEAD, S_PURGE, S_RESULT
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [PTR_W-1:0] slot;
        logic [31:0]      timeout;
        logic [31:0]      message;
        logic [3:0]       queue;
        logic [7:0]       task_id;
    } t_item;

endpackage

FILE: hdl/sttq_front.sv
module sttq_front import sttq_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_slot_index,
    input  logic [31:0] i_timeout,
    input  logic [31:0] i_message,
    input  logic [3:0]  i_queue_id,
    input  logic [7:0]  i_task_id,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    logic [1:0] r_cnt;
    logic       r_wr;
    logic       r_rd;
    t_item      r_buf [2];
    t_item      dec;
    logic       in_range;
    logic       push;

    assign in_range = 7'(i_slot_index) < 7'(SLOTS);

    // classify the mode; slot ops beyond the pool collapse to a plain ack
    always_comb begin
        dec.slot    = PTR_W'(i_slot_index);
        dec.timeout = i_timeout;
        dec.message = i_message;
        dec.queue   = i_queue_id;
        dec.task_id = i_task_id;
        unique case (i_mode)
            MODE_TICK:    dec.op = OP_TICK;
            MODE_ALLOC:   dec.op = OP_ALLOC;
            MODE_RESET:   dec.op = in_range ? OP_RESET : OP_NONE;
            MODE_CANCEL:  dec.op = in_range ? OP_CANCEL : OP_NONE;
            MODE_RELEASE: dec.op = in_range ? OP_RELEASE : OP_NONE;
            MODE_PURGE:   dec.op = OP_PURGE;
            default:      dec.op = OP_NONE;
        endcase
    end

    assign o_stall      = r_cnt[1];
    assign push         = i_valid && !o_stall;
    assign o_item_valid = r_cnt != 2'd0;
    assign o_item       = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wr] <= dec;
    end

endmodule

FILE: hdl/sttq_back.sv
module sttq_back import sttq_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_ok,
    output logic [4:0]  o_slot_out,
    output logic [31:0] o_message_out,
    output logic [3:0]  o_queue_out,
    output logic        o_task_switch,
    output logic        o_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam logic [PTR_W:0] SLOTS_P = (PTR_W + 1)'(SLOTS);
    localparam logic [NW-1:0]  SLOTS_N = NW'(SLOTS);

    t_state  r_state, n_state;
    t_after  r_after, n_after;
    logic [31:0] r_count, n_count;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_cur, n_cur;
    logic [PTR_W-1:0] r_prev, n_prev;
    logic [NW-1:0] r_n, n_n;
    logic [PTR_W-1:0] r_slot, n_slot;
    logic [31:0] r_tmo, n_tmo;
    logic [31:0] r_msg, n_msg;
    logic [7:0]  r_task, n_task;
    logic        r_alloc, n_alloc;
    logic        r_ts, n_ts;
    t_kind       r_rkind, n_rkind;
    logic        r_rok, n_rok;

    t_status     r_status [SLOTS];
    logic [31:0] m_tmo  [SLOTS];
    logic [31:0] m_msg  [SLOTS];
    logic [3:0]  m_q    [SLOTS];
    logic [7:0]  m_task [SLOTS];
    logic [PTR_W-1:0] m_link [SLOTS];

    logic        r_ov;
    t_kind       r_okind;
    logic        r_ook;
    logic [4:0]  r_oslot;
    logic [31:0] r_omsg;
    logic [3:0]  r_oq;
    logic        r_ots;
    logic        r_olast;

    // single read address into the slot stores
    logic [PTR_W-1:0] rd_ptr;
    logic [SW-1:0]    rd_i;
    logic [31:0]      rd_tmo, rd_msg;
    logic [3:0]       rd_q;
    logic [7:0]       rd_task;
    logic [PTR_W-1:0] rd_link;
    logic             rd_ok;
    logic             walk_ok;
    t_status          item_st;

    logic             any_free;
    logic [SW-1:0]    free_i;

    logic             st_we;
    logic [SW-1:0]    st_addr;
    t_status          st_data;
    logic             ln_we;
    logic [SW-1:0]    ln_addr;
    logic [PTR_W-1:0] ln_data;
    logic             tm_we;
    logic             qt_we;
    logic [SW-1:0]    qt_addr;

    logic        out_free;
    logic        em;
    t_kind       em_kind;
    logic        em_ok;
    logic [4:0]  em_slot;
    logic [31:0] em_msg;
    logic [3:0]  em_q;
    logic        em_ts;
    logic        em_last;

    assign rd_ptr  = (r_state == S_TICK) ? r_head : r_cur;
    assign rd_i    = rd_ptr[SW-1:0];
    assign rd_tmo  = m_tmo[rd_i];
    assign rd_msg  = m_msg[rd_i];
    assign rd_q    = m_q[rd_i];
    assign rd_task = m_task[rd_i];
    assign rd_link = m_link[rd_i];
    assign rd_ok   = {1'b0, rd_ptr} < SLOTS_P;
    assign walk_ok = rd_ok && (r_n < SLOTS_N);
    assign item_st = r_status[i_item.slot[SW-1:0]];
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        any_free = 1'b0;
        free_i   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_status[s] == ST_FREE) begin
                any_free = 1'b1;
                free_i   = SW'(s);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_count = r_count;
        n_head  = r_head;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_n     = r_n;
        n_slot  = r_slot;
        n_tmo   = r_tmo;
        n_msg   = r_msg;
        n_task  = r_task;
        n_alloc = r_alloc;
        n_ts    = r_ts;
        n_rkind = r_rkind;
        n_rok   = r_rok;
        o_pop   = 1'b0;
        st_we   = 1'b0;
        st_addr = r_slot[SW-1:0];
        st_data = ST_IDLE;
        ln_we   = 1'b0;
        ln_addr = r_slot[SW-1:0];
        ln_data = NO_SLOT;
        tm_we   = 1'b0;
        qt_we   = 1'b0;
        qt_addr = free_i;
        em      = 1'b0;
        em_kind = KIND_ACK;
        em_ok   = 1'b0;
        em_slot = '0;
        em_msg  = '0;
        em_q    = '0;
        em_ts   = 1'b0;
        em_last = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_slot  = i_item.slot;
                    n_tmo   = i_item.timeout;
                    n_msg   = i_item.message;
                    n_task  = i_item.task_id;
                    n_alloc = 1'b0;
                    n_ts    = 1'b0;
                    n_cur   = r_head;
                    n_prev  = NO_SLOT;
                    n_n     = '0;
                    n_rkind = KIND_ACK;
                    n_rok   = 1'b0;
                    n_state = S_RESULT;
                    unique case (i_item.op)
                        OP_TICK: begin
                            n_count = r_count + 32'd1;
                            n_state = S_TICK;
                        end
                        OP_ALLOC: begin
                            n_rkind = KIND_ALLOC;
                            if (any_free) begin
                                n_slot  = PTR_W'(free_i);
                                n_alloc = 1'b1;
                                qt_we   = 1'b1;
                                st_we   = 1'b1;
                                st_addr = free_i;
                                st_data = ST_IDLE;
                                n_state = S_ARM;
                            end
                        end
                        OP_RESET: begin
                            if (item_st == ST_RUN) begin
                                n_after = AFT_ARM;
                                n_state = S_UNLINK;
                            end else if (item_st == ST_IDLE) begin
                                n_state = S_ARM;
                            end
                        end
                        OP_CANCEL: begin
                            if (item_st == ST_RUN) begin
                                n_after = AFT_IDLE;
                                n_state = S_UNLINK;
                            end
                        end
                        OP_RELEASE: begin
                            if (item_st == ST_RUN) begin
                                n_after = AFT_FREE;
                                n_state = S_UNLINK;
                            end else begin
                                st_we   = 1'b1;
                                st_addr = i_item.slot[SW-1:0];
                                st_data = ST_FREE;
                            end
                        end
                        OP_PURGE: n_state = S_PURGE;
                        default:  n_state = S_RESULT;
                    endcase
                end
            end
            S_TICK: begin
                if (walk_ok && (r_count > rd_tmo)) begin
                    if (rd_msg == SWITCH_MARK || out_free) begin
                        st_we   = 1'b1;
                        st_addr = rd_i;
                        st_data = ST_IDLE;
                        n_head  = rd_link;
                        n_n     = r_n + 1'b1;
                        if (rd_msg == SWITCH_MARK) begin
                            n_ts = 1'b1;
                        end else begin
                            em      = 1'b1;
                            em_kind = KIND_EXPIRY;
                            em_slot = rd_ptr[4:0];
                            em_msg  = rd_msg;
                            em_q    = rd_q;
                            em_last = 1'b0;
                        end
                    end
                end else if (out_free) begin
                    em      = 1'b1;
                    em_kind = KIND_DONE;
                    em_ts   = r_ts;
                    n_state = S_IDLE;
                end
            end
            S_UNLINK: begin
                if (walk_ok && r_cur != r_slot) begin
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    n_n    = r_n + 1'b1;
                end else begin
                    if (walk_ok) begin
                        if (r_prev == NO_SLOT) begin
                            n_head = rd_link;
                        end else begin
                            ln_we   = 1'b1;
                            ln_addr = r_prev[SW-1:0];
                            ln_data = rd_link;
                        end
                    end
                    unique case (r_after)
                        AFT_ARM: n_state = S_ARM;
                        AFT_IDLE: begin
                            st_we   = 1'b1;
                            st_data = ST_IDLE;
                            n_state = S_RESULT;
                        end
                        default: begin
                            st_we   = 1'b1;
                            st_data = ST_FREE;
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_ARM: begin
                tm_we   = 1'b1;
                st_we   = 1'b1;
                st_data = ST_RUN;
                n_cur   = r_head;
                n_prev  = NO_SLOT;
                n_n     = '0;
                n_state = S_INSERT;
            end
            S_INSERT: begin
                if (walk_ok && (r_tmo > rd_tmo)) begin
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    n_n    = r_n + 1'b1;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                ln_we   = 1'b1;
                ln_data = rd_ok ? r_cur : NO_SLOT;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (r_prev == NO_SLOT) begin
                    n_head = r_slot;
                end else begin
                    ln_we   = 1'b1;
                    ln_addr = r_prev[SW-1:0];
                    ln_data = r_slot;
                end
                n_rok   = r_alloc;
                n_state = S_RESULT;
            end
            S_PURGE: begin
                if (walk_ok) begin
                    n_cur = rd_link;
                    n_n   = r_n + 1'b1;
                    if (rd_task == r_task) begin
                        st_we   = 1'b1;
                        st_addr = rd_i;
                        st_data = ST_IDLE;
                        if (r_prev == NO_SLOT) begin
                            n_head = rd_link;
                        end else begin
                            ln_we   = 1'b1;
                            ln_addr = r_prev[SW-1:0];
                            ln_data = rd_link;
                        end
                    end else begin
                        n_prev = r_cur;
                    end
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    em      = 1'b1;
                    em_kind = r_rkind;
                    em_ok   = r_rok;
                    em_slot = r_rok ? r_slot[4:0] : 5'd0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= NO_SLOT;
            r_ov    <= 1'b0;
            for (int s = 0; s < SLOTS; s++) r_status[s] <= ST_FREE;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            if (st_we) r_status[st_addr] <= st_data;
            if (em) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after <= n_after;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_n     <= n_n;
        r_slot  <= n_slot;
        r_tmo   <= n_tmo;
        r_msg   <= n_msg;
        r_task  <= n_task;
        r_alloc <= n_alloc;
        r_ts    <= n_ts;
        r_rkind <= n_rkind;
        r_rok   <= n_rok;
        if (em) begin
            r_okind <= em_kind;
            r_ook   <= em_ok;
            r_oslot <= em_slot;
            r_omsg  <= em_msg;
            r_oq    <= em_q;
            r_ots   <= em_ts;
            r_olast <= em_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) m_link[ln_addr] <= ln_data;
        if (tm_we) begin
            m_tmo[r_slot[SW-1:0]] <= r_tmo;
            m_msg[r_slot[SW-1:0]] <= r_msg;
        end
        if (qt_we) begin
            m_q[qt_addr]    <= i_item.queue;
            m_task[qt_addr] <= i_item.task_id;
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_okind;
    assign o_ok          = r_ook;
    assign o_slot_out    = r_oslot;
    assign o_message_out = r_omsg;
    assign o_queue_out   = r_oq;
    assign o_task_switch = r_ots;
    assign o_last        = r_olast;

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NO_SLOT) || ({1'b0, r_head} < SLOTS_P))
        else $error("list head points outside the pool");

    a_insert_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT && walk_ok) |-> (r_cur != r_slot))
        else $error("slot being inserted is still on the list");

    // walk counter is only meaningful once a command has been taken
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= SLOTS_N))
        else $error("list walk ran past the pool size");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE) || !$past(i_item.op == OP_TICK))
        else $error("tick taken without walking the list");

endmodule

FILE: hdl/sorted_timer_queue.sv
// sorted timer queue: a pool of SLOTS timer slots with one list of running
// timers kept in ascending timeout order (newest first among equal timeouts)
// input channel: i_valid / o_stall, one beat per command (tick, allocate,
// reset slot, cancel, release, purge task); a two-entry queue holds
// commands so the producer may run ahead of the list engine
// output channel: o_valid / i_stall, one beat per result; o_last marks the
// final beat of a command
// a tick gives one expiry beat per expired slot not carrying the switch
// marker, then a tick-done beat with o_task_switch
// walks: a tick takes the expired slots, allocate an ordered insert, reset
// an unlink of a running slot then an insert, cancel and release an unlink
// of a running slot, purge the whole list; one list node per cycle through
// the single slot-store read port, a tick pausing while its output stalls
// a stalled output holds its beat and the engine waits only when it has a
// further beat to give; commands keep queueing meanwhile
// reset (i_rst_n low, synchronous) frees every slot, empties the list and
// clears the tick counter; no clearing pass is needed
module sorted_timer_queue import sttq_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_slot_index,
    input  logic [31:0] i_timeout,
    input  logic [31:0] i_message,
    input  logic [3:0]  i_queue_id,
    input  logic [7:0]  i_task_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_ok,
    output logic [4:0]  o_slot_out,
    output logic [31:0] o_message_out,
    output logic [3:0]  o_queue_out,
    output logic        o_task_switch,
    output logic        o_last
);

    t_item item;
    logic  item_valid;
    logic  pop;

    // front end: decode and queue commands
    sttq_front #(.SLOTS(SLOTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_slot_index (i_slot_index),
        .i_timeout    (i_timeout),
        .i_message    (i_message),
        .i_queue_id   (i_queue_id),
        .i_task_id    (i_task_id),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    // back end: list engine, slot stores and output register
    sttq_back #(.SLOTS(SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_ok          (o_ok),
        .o_slot_out    (o_slot_out),
        .o_message_out (o_message_out),
        .o_queue_out   (o_queue_out),
        .o_task_switch (o_task_switch),
        .o_last        (o_last)
    );

endmodule

FILE: tb/sorted_timer_queue_tb.sv
module sorted_timer_queue_tb;
    import sttq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam logic [2:0] MODE_BAD6 = 3'd6;
    localparam logic [2:0] MODE_BAD7 = 3'd7;

    // one result beat as the block gives it
    typedef struct packed {
        t_kind       kind;
        logic        ok;
        logic [4:0]  slot;
        logic [31:0] message;
        logic [3:0]  queue;
        logic        task_switch;
        logic        last;
    } t_beat;

    // scoreboard: own copy of the timer pool and the queue of beats still owed
    class timer_scoreboard;
        logic [31:0] ticks;
        t_status     status [NSLOT];
        logic [31:0] deadline [NSLOT];
        logic [31:0] word [NSLOT];
        logic [3:0]  dest [NSLOT];
        logic [7:0]  owner [NSLOT];
        logic [5:0]  link [NSLOT];
        logic [5:0]  head;
        t_beat       owed [$];
        int          mismatches;

        function new();
            ticks = 0;
            head = NO_SLOT;
            mismatches = 0;
            foreach (status[i]) begin
                status[i] = ST_FREE;
                deadline[i] = 0; word[i] = 0; dest[i] = 0; owner[i] = 0; link[i] = 0;
            end
        endfunction

        function void owe(t_kind k, logic ok, logic [4:0] s, logic [31:0] m,
                          logic [3:0] q, logic ts, logic l);
            t_beat b;
            b.kind = k; b.ok = ok; b.slot = s; b.message = m;
            b.queue = q; b.task_switch = ts; b.last = l;
            owed.push_back(b);
        endfunction

        // newest goes before equal deadlines
        function void place(int s);
            int prev, cur, n;
            prev = NO_SLOT; cur = head; n = 0;
            while (cur < NSLOT && n < NSLOT && deadline[s] > deadline[cur]) begin
                prev = cur; cur = link[cur]; n++;
            end
            link[s] = (cur < NSLOT) ? 6'(cur) : NO_SLOT;
            if (prev == NO_SLOT) head = 6'(s);
            else link[prev] = 6'(s);
        endfunction

        function void unplace(int s);
            int prev, cur, n;
            prev = NO_SLOT; cur = head; n = 0;
            while (cur < NSLOT && n < NSLOT) begin
                if (cur == s) begin
                    if (prev == NO_SLOT) head = link[cur];
                    else link[prev] = link[cur];
                    return;
                end
                prev = cur; cur = link[cur]; n++;
            end
        endfunction

        function void arm(int s, logic [31:0] t, logic [31:0] m);
            if (status[s] == ST_RUN) unplace(s);
            deadline[s] = t; word[s] = m; status[s] = ST_RUN;
            place(s);
        endfunction

        function void note_command(logic [2:0] mode, logic [4:0] idx, logic [31:0] t,
                                   logic [31:0] m, logic [3:0] q, logic [7:0] tk);
            int s, prev, cur, nxt, n;
            logic ts;
            case (mode)
                MODE_TICK: begin
                    ts = 0; n = 0;
                    ticks = ticks + 1;
                    while (head < NSLOT && n < NSLOT && ticks > deadline[head]) begin
                        s = head;
                        if (word[s] == SWITCH_MARK) ts = 1;
                        else owe(KIND_EXPIRY, 0, 5'(s), word[s], dest[s], 0, 0);
                        status[s] = ST_IDLE;
                        head = link[s];
                        n++;
                    end
                    owe(KIND_DONE, 0, 0, 0, 0, ts, 1);
                end
                MODE_ALLOC: begin
                    for (s = 0; s < NSLOT; s++)
                        if (status[s] == ST_FREE) break;
                    if (s < NSLOT) begin
                        dest[s] = q; owner[s] = tk; status[s] = ST_IDLE;
                        arm(s, t, m);
                        owe(KIND_ALLOC, 1, 5'(s), 0, 0, 0, 1);
                    end else begin
                        owe(KIND_ALLOC, 0, 0, 0, 0, 0, 1);
                    end
                end
                MODE_RESET: begin
                    if (status[idx] != ST_FREE) arm(idx, t, m);
                    owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
                end
                MODE_CANCEL, MODE_RELEASE: begin
                    if (status[idx] == ST_RUN) begin
                        unplace(idx);
                        status[idx] = ST_IDLE;
                    end
                    if (mode == MODE_RELEASE) status[idx] = ST_FREE;
                    owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
                end
                MODE_PURGE: begin
                    prev = NO_SLOT; cur = head; n = 0;
                    while (cur < NSLOT && n < NSLOT) begin
                        nxt = link[cur];
                        if (owner[cur] == tk) begin
                            status[cur] = ST_IDLE;
                            if (prev == NO_SLOT) head = 6'(nxt);
                            else link[prev] = 6'(nxt);
                        end else begin
                            prev = cur;
                        end
                        cur = nxt; n++;
                    end
                    owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
                end
                default: owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d slot %0d msg %h", got.kind,
                             got.slot, got.message);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: want k%0d ok%0d s%0d m%h q%0d ts%0d l%0d, got k%0d ok%0d s%0d m%h q%0d ts%0d l%0d",
                             want.kind, want.ok, want.slot, want.message, want.queue,
                             want.task_switch, want.last, got.kind, got.ok, got.slot,
                             got.message, got.queue, got.task_switch, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_mode = 0;
    logic [4:0]  i_slot_index = 0;
    logic [31:0] i_timeout = 0;
    logic [31:0] i_message = 0;
    logic [3:0]  i_queue_id = 0;
    logic [7:0]  i_task_id = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_kind;
    logic        o_ok;
    logic [4:0]  o_slot_out;
    logic [31:0] o_message_out;
    logic [3:0]  o_queue_out;
    logic        o_task_switch;
    logic        o_last;

    timer_scoreboard timers = new();
    int send_idle_pct = 20;
    int recv_idle_pct = 62;

    sorted_timer_queue dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // receiver: random stall, results checked at the edge they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            timers.check_beat({t_kind'(o_kind), o_ok, o_slot_out, o_message_out,
                               o_queue_out, o_task_switch, o_last});
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // one input beat; optional idle gap before it, valid held until taken
    task automatic send(logic [2:0] mode, logic [4:0] idx, logic [31:0] t,
                        logic [31:0] m, logic [3:0] q, logic [7:0] tk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_mode <= mode; i_slot_index <= idx; i_timeout <= t;
        i_message <= m; i_queue_id <= q; i_task_id <= tk;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        timers.note_command(mode, idx, t, m, q, tk);
    endtask

    task automatic go_quiet();
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    // one random command; its slot index is random and may name a free slot
    // (reset of a free slot is fine, the block ignores it)
    task automatic random_command();
        int r;
        logic [31:0] t, m;
        r = $urandom_range(99);
        t = timers.ticks + $urandom_range(12);
        if ($urandom_range(9) == 0) t = $urandom;
        m = ($urandom_range(5) == 0) ? SWITCH_MARK : $urandom;
        if (r < 35)      send(MODE_TICK, 5'($urandom), $urandom, $urandom, 4'($urandom),
                              8'($urandom));
        else if (r < 60) send(MODE_ALLOC, 5'($urandom), t, m, 4'($urandom),
                              8'($urandom_range(3)));
        else if (r < 72) send(MODE_RESET, 5'($urandom), t, m, 4'($urandom), 8'($urandom));
        else if (r < 82) send(MODE_CANCEL, 5'($urandom), $urandom, $urandom, 4'($urandom),
                              8'($urandom));
        else if (r < 90) send(MODE_RELEASE, 5'($urandom), $urandom, $urandom, 4'($urandom),
                              8'($urandom));
        else if (r < 97) send(MODE_PURGE, 5'($urandom), $urandom, $urandom, 4'($urandom),
                              8'($urandom_range(3)));
        else             send($urandom_range(1) ? MODE_BAD6 : MODE_BAD7, 5'($urandom),
                              $urandom, $urandom, 4'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (timers.owed.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: allocate, equal deadlines, markers, every mode, extremes
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_ALLOC, 0, 32'd3, 32'hFFFF_FFFF, 4'hF, 8'hFF);
        send(MODE_ALLOC, 0, 32'd3, 32'h0, 4'h0, 8'h00);
        send(MODE_ALLOC, 0, 32'd2, SWITCH_MARK, 4'h5, 8'h01);
        send(MODE_ALLOC, 0, 32'hFFFF_FFFF, 32'h1234_5678, 4'hA, 8'h01);
        send(MODE_RESET, 5'd31, 32'd1, 32'd1, 0, 0);
        send(MODE_RESET, 5'd1, 32'd1, 32'hA5A5_5A5A, 0, 0);
        send(MODE_CANCEL, 5'd3, 0, 0, 0, 0);
        send(MODE_CANCEL, 5'd3, 0, 0, 0, 0);
        send(MODE_RESET, 5'd3, 32'd4, 32'h0, 0, 0);
        send(MODE_PURGE, 0, 0, 0, 0, 8'h01);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_RELEASE, 5'd0, 0, 0, 0, 0);
        send(MODE_RELEASE, 5'd31, 0, 0, 0, 0);
        send(MODE_BAD6, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF);
        send(MODE_BAD7, 0, 0, 0, 0, 0);
        // fill the pool to the brim, then allocate past it
        for (int i = 0; i < 33; i++)
            send(MODE_ALLOC, 0, timers.ticks + 1 + (i % 3), i, i[3:0], 8'h07);
        repeat (4) send(MODE_TICK, 0, 0, 0, 0, 0);
        for (int i = 0; i < 32; i++) send(MODE_RELEASE, 5'(i), 0, 0, 0, 0);
        go_quiet();
        drain();

        // three pacing phases
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin send_idle_pct = 62; recv_idle_pct = 20; end
            if (p == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            repeat (7) random_command();
            go_quiet();
        end
        drain();

        // counter wrap: deadlines near the top of the range, then a long tick run is
        // too slow, so only check plain large deadlines stay put
        send(MODE_ALLOC, 0, 32'hFFFF_FFFE, 32'h0BAD_F00D, 4'h3, 8'h09);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        go_quiet();
        drain();

        if (timers.mismatches == 0 && timers.owed.size() == 0)
            $display("sorted_timer_queue test passed");
        else
            $display("sorted_timer_queue test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("sorted_timer_queue test failed");
        $finish;
    end
endmodule

FILE: sorted_timer_queue.f
hdl/sttq_pkg.sv
hdl/sttq_front.sv
hdl/sttq_back.sv
hdl/sorted_timer_queue.sv
tb/sorted_timer_queue_tb.sv
